>>> sv/scp_pkg.sv
// Shared types, codes and constants of the scope capture trigger.
`timescale 1ns / 1ps
package scp_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int RING_WORDS_DEF = 4096;
  localparam int CODE_FIELDS    = 4;
  localparam int CODE_W         = 14;
  localparam int SUM_W          = 30;
  localparam int SAMPLE_W       = 16;
  localparam int DEC_W          = 16;
  localparam int REQ_W          = 3;
  localparam int IN_DATA_W      = 104;
  localparam int OUT_DATA_W     = 56;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ARM     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SCAN    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TIME    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ABORT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_OVERRUN = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECLEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGCTL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd7;

  // trigger modes
  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_AUTO = 2'd1;
  localparam logic [1:0] MODE_NORM = 2'd2;

  // read status codes
  localparam logic [1:0] RD_OK     = 2'd0;
  localparam logic [1:0] RD_NOREC  = 2'd1;
  localparam logic [1:0] RD_RANGE  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FILLING  = 3'd1,
    PH_WAITING  = 3'd2,
    PH_POST     = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_ABORTED  = 3'd5,
    PH_OVERRUN  = 3'd6
  } phase_e;

  typedef struct packed {
    logic clr;   // zero the running sum
    logic scan;  // add this scan's code
    logic fin;   // close the frame and start the average
  } lane_ctl_t;

endpackage

>>> sv/scope_capture_trigger.sv
// Top level of the scope capture trigger: request decode, acquisition control, frame ring.
//
// Usage:
//   Requests enter on the s_axis channel; tuser carries the request kind (arm, scan,
//   time check, abort, overrun, read) and tdata its operands. Every request yields
//   exactly one status item on m_axis: acquisition phase, frame counts, trigger
//   position and, for a read, one stored sample with its status.
//   Configuration goes through cfg_we_i / cfg_index_i / cfg_data_i and is taken only
//   while no acquisition runs; an accepted write returns the phase to idle.
// Timing:
//   A request goes from accept through the result state to the output register. A scan
//   that closes a frame first runs the lane dividers (one quotient bit each per cycle, all
//   lanes side by side) and then writes one ring word per enabled slot through the single
//   RAM write port. A read issues the RAM read at accept and takes the registered RAM data.
//   One request is in flight at a time; s_axis_tready is high only when idle.
// Reset:
//   Configuration takes its default values, the phase goes idle and no frame counts
//   remain. Ring contents are not cleared; reads are served only from a complete
//   record, whose entries have all been written.
// Stall:
//   The result holds on m_axis until taken; no new request is accepted meanwhile.
`timescale 1ns / 1ps
module scope_capture_trigger #(
  parameter int CHANNELS   = scp_pkg::CHANNELS_DEF,
  parameter int RING_WORDS = scp_pkg::RING_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request item
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: code_0[13:0], code_1[27:14], code_2[41:28], code_3[55:42],
  //        now_ms[87:56], read_index[99:88], read_channel[101:100], zero pad
  input  logic [scp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: req_type[2:0]
  input  logic [scp_pkg::REQ_W-1:0]         s_axis_tuser,
  // result item
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: acq_state[2:0], is_active[3], was_triggered[4], frames_available[17:5],
  //        trigger_position[29:18], read_data[45:30], read_status[47:46],
  //        timed_out[48], zero pad
  output logic [scp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [scp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import scp_pkg::*;

  localparam int NL = (CHANNELS < CODE_FIELDS) ? CHANNELS : CODE_FIELDS;
  localparam int LW = (NL > 1) ? $clog2(NL) : 1;
  localparam int AW = $clog2(RING_WORDS);
  localparam int FW = $clog2(RING_WORDS + 1);
  localparam int XW = (FW > 13) ? FW : 13;
  localparam logic [FW-1:0] RF1 = FW'(RING_WORDS);
  localparam logic [FW-1:0] RF2 = FW'(RING_WORDS / 2);
  localparam logic [FW-1:0] RF3 = FW'(RING_WORDS / 3);
  localparam logic [FW-1:0] RF4 = FW'(RING_WORDS / 4);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_WR   = 5'b00100,
    ST_RES  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // configuration registers
  logic [2:0]  slots_cfg_q, slots_cfg_d;
  logic [15:0] decim_q, decim_d;
  logic [12:0] reclen_q, reclen_d;
  logic [11:0] pretrig_q, pretrig_d;
  logic [4:0]  trigctl_q, trigctl_d;
  logic [15:0] level_q, level_d;
  logic [15:0] hyst_q, hyst_d;
  logic [15:0] tmo_q, tmo_d;

  // acquisition state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [31:0]     fw_q, fw_d;
  logic [AW-1:0]   wf_q, wf_d;
  logic [AW-1:0]   start_q, start_d;
  logic [12:0]     post_q, post_d;
  logic [15:0]     sc_q, sc_d;
  logic [31:0]     armed_q, armed_d;
  logic            seen_q, seen_d;
  logic            edge_q, edge_d;
  logic [AW-1:0]   base_q, base_d;
  logic [LW-1:0]   wcnt_q, wcnt_d;
  logic [1:0]      rstat_q, rstat_d;
  logic            tout_q, tout_d;
  logic            rdok_q, rdok_d;
  logic            out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_q, out_d;

  // request fields
  logic [REQ_W-1:0] req;
  logic [31:0]      now_ms;
  logic [11:0]      rd_index;
  logic [1:0]       rd_chan;
  logic             in_acc;

  // derived configuration
  logic [2:0]  slots;
  logic [FW-1:0] rf;
  logic [12:0] rlen_raw, rl;
  logic [11:0] pre;
  logic [1:0]  mode;
  logic [1:0]  tslot;
  logic [15:0] dec_eff;
  logic        running;

  // lanes and ring
  lane_ctl_t              lane_ctl;
  logic [NL-1:0]          lane_busy;
  logic [SAMPLE_W-1:0]    lane_avg [NL];
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]    ram_wdata, ram_rdata;

  assign req      = s_axis_tuser;
  assign now_ms   = s_axis_tdata[87:56];
  assign rd_index = s_axis_tdata[99:88];
  assign rd_chan  = s_axis_tdata[101:100];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // position a - b around the ring, b no larger than the ring
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] a, input logic [12:0] b,
                                              input logic [FW-1:0] r);
    logic [XW:0] ax, bx, rx, res;
    ax  = (XW+1)'(a);
    bx  = (XW+1)'(b);
    rx  = (XW+1)'(r);
    res = (ax >= bx) ? ax - bx : ax + rx - bx;
    return res[AW-1:0];
  endfunction

  always_comb begin
    logic [XW-1:0] rlx, rfx;
    slots = (slots_cfg_q == 3'd0) ? 3'd1 :
            ((32'(slots_cfg_q) > NL) ? 3'(NL) : slots_cfg_q);
    unique case (slots)
      3'd1:    rf = RF1;
      3'd2:    rf = RF2;
      3'd3:    rf = RF3;
      default: rf = RF4;
    endcase
    rlen_raw = (reclen_q == 13'd0) ? 13'd1 : reclen_q;
    rlx      = XW'(rlen_raw);
    rfx      = XW'(rf);
    rl       = (rlx > rfx) ? rfx[12:0] : rlen_raw;
    pre      = ({1'b0, pretrig_q} < rl) ? pretrig_q : 12'(rl - 13'd1);
    mode     = (trigctl_q[1:0] == 2'd3) ? MODE_NORM : trigctl_q[1:0];
    tslot    = ({1'b0, trigctl_q[4:3]} < slots) ? trigctl_q[4:3] : 2'd0;
    dec_eff  = (decim_q == 16'd0) ? 16'd1 : decim_q;
    running  = (phase_q == PH_FILLING) || (phase_q == PH_WAITING) || (phase_q == PH_POST);
  end

  // lanes work on their slots side by side
  for (genvar i = 0; i < NL; i++) begin : g_lane
    scp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .en_i   (3'(i) < slots),
      .code_i (s_axis_tdata[i*CODE_W +: CODE_W]),
      .dec_i  (dec_eff),
      .busy_o (lane_busy[i]),
      .avg_o  (lane_avg[i])
    );
  end

  scp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_WORDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [15:0]     sc_next;
    logic [FW-1:0]   wf_inc;
    logic [AW-1:0]   wf_next;
    logic            eval, fire;
    logic [15:0]     sample;
    logic signed [17:0] s_x, lvl_x, lo_x, hi_x;
    logic [12:0]     post_len;
    logic [XW:0]     rsum, rfw;
    logic [AW+2:0]   prod;
    logic [12:0]     favail;

    slots_cfg_d = slots_cfg_q;
    decim_d     = decim_q;
    reclen_d    = reclen_q;
    pretrig_d   = pretrig_q;
    trigctl_d   = trigctl_q;
    level_d     = level_q;
    hyst_d      = hyst_q;
    tmo_d       = tmo_q;
    state_d     = state_q;
    phase_d     = phase_q;
    fw_d        = fw_q;
    wf_d        = wf_q;
    start_d     = start_q;
    post_d      = post_q;
    sc_d        = sc_q;
    armed_d     = armed_q;
    seen_d      = seen_q;
    edge_d      = edge_q;
    base_d      = base_q;
    wcnt_d      = wcnt_q;
    rstat_d     = rstat_q;
    tout_d      = tout_q;
    rdok_d      = rdok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    lane_ctl    = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = base_q + AW'(wcnt_q);
    ram_wdata   = lane_avg[wcnt_q];

    sc_next  = sc_q + 16'd1;
    wf_inc   = FW'(wf_q) + FW'(1);
    wf_next  = (wf_inc >= rf) ? '0 : wf_inc[AW-1:0];
    sample   = lane_avg[LW'(tslot)];
    s_x      = 18'(sample);
    lvl_x    = 18'(level_q);
    lo_x     = lvl_x - 18'(hyst_q);
    hi_x     = lvl_x + 18'(hyst_q);
    post_len = rl - 13'(pre) - 13'd1;
    eval     = 1'b0;
    fire     = 1'b0;

    // read address: (record start + index) around the ring, then slot within frame
    rfw       = (XW+1)'(rf);
    rsum      = (XW+1)'(start_q) + (XW+1)'(rd_index);
    if (rsum >= rfw) begin
      rsum = rsum - rfw;
    end
    prod      = (AW+3)'(rsum[AW-1:0]) * (AW+3)'(slots) + (AW+3)'(rd_chan);
    ram_raddr = prod[AW-1:0];

    favail = (phase_q == PH_COMPLETE) ? rl : ((fw_q < 32'(rl)) ? fw_q[12:0] : rl);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rstat_d = RD_OK;
          tout_d  = 1'b0;
          rdok_d  = 1'b0;
          state_d = ST_RES;
          case (req)
            REQ_ARM: begin
              // restart: clear sums, counts and trigger history
              lane_ctl.clr = 1'b1;
              fw_d    = '0;
              start_d = '0;
              wf_d    = '0;
              sc_d    = '0;
              seen_d  = 1'b0;
              edge_d  = 1'b0;
              armed_d = now_ms;
              phase_d = PH_FILLING;
            end
            REQ_SCAN: begin
              if (running) begin
                lane_ctl.scan = 1'b1;
                if (sc_next >= dec_eff) begin
                  sc_d         = '0;
                  lane_ctl.fin = 1'b1;
                  state_d      = ST_DIV;
                end else begin
                  sc_d = sc_next;
                end
              end
            end
            REQ_TIME: begin
              if (mode == MODE_AUTO &&
                  (phase_q == PH_FILLING || phase_q == PH_WAITING) &&
                  (now_ms - armed_q) >= 32'(tmo_q) && fw_q >= 32'(rl)) begin
                start_d = ring_back(wf_q, rl, rf);
                seen_d  = 1'b0;
                phase_d = PH_COMPLETE;
                tout_d  = 1'b1;
              end
            end
            REQ_ABORT: begin
              if (running) begin
                phase_d = PH_ABORTED;
              end
            end
            REQ_OVERRUN: begin
              if (running) begin
                phase_d = PH_OVERRUN;
              end
            end
            REQ_READ: begin
              if (phase_q != PH_COMPLETE) begin
                rstat_d = RD_NOREC;
              end else if ({1'b0, rd_index} >= rl || {1'b0, rd_chan} >= slots) begin
                rstat_d = RD_RANGE;
              end else begin
                rdok_d = 1'b1;
                ram_re = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (!(|lane_busy)) begin
          // frame closed: advance counters and run the trigger
          fw_d   = fw_q + 32'd1;
          wf_d   = wf_next;
          prod   = (AW+3)'(wf_q) * (AW+3)'(slots);
          base_d = prod[AW-1:0];
          wcnt_d = '0;
          state_d = ST_WR;
          if (phase_q == PH_FILLING) begin
            if (mode == MODE_FREE) begin
              if (fw_d >= 32'(rl)) begin
                start_d = ring_back(wf_next, rl, rf);
                seen_d  = 1'b0;
                phase_d = PH_COMPLETE;
              end
            end else if (fw_q >= 32'(pre)) begin
              phase_d = PH_WAITING;
              eval    = 1'b1;
            end
          end else if (phase_q == PH_WAITING) begin
            eval = 1'b1;
          end else if (phase_q == PH_POST) begin
            post_d = post_q - 13'd1;
            if (post_q == 13'd1) begin
              phase_d = PH_COMPLETE;
            end
          end
          if (eval) begin
            if (!trigctl_q[2]) begin
              if (s_x < lo_x) begin
                edge_d = 1'b1;
              end else if (edge_q && s_x >= lvl_x) begin
                fire = 1'b1;
              end
            end else begin
              if (s_x > hi_x) begin
                edge_d = 1'b1;
              end else if (edge_q && s_x <= lvl_x) begin
                fire = 1'b1;
              end
            end
            if (fire) begin
              start_d = ring_back(wf_q, 13'(pre), rf);
              seen_d  = 1'b1;
              post_d  = post_len;
              phase_d = (post_len == 13'd0) ? PH_COMPLETE : PH_POST;
            end
          end
        end
      end
      ST_WR: begin
        // one ring word per enabled slot
        ram_we = 1'b1;
        if (3'(wcnt_q) == slots - 3'd1) begin
          state_d = ST_RES;
        end else begin
          wcnt_d = wcnt_q + LW'(1);
        end
      end
      ST_RES: begin
        out_d = '0;
        out_d[2:0]   = phase_q;
        out_d[3]     = running;
        out_d[4]     = seen_q;
        out_d[17:5]  = favail;
        out_d[29:18] = seen_q ? pre : 12'd0;
        out_d[45:30] = rdok_q ? ram_rdata : '0;
        out_d[47:46] = rstat_q;
        out_d[48]    = tout_q;
        out_valid_d  = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // configuration writes land only between acquisitions
    if (cfg_we_i && !running) begin
      unique case (cfg_index_i)
        CFG_SLOTS:   slots_cfg_d = cfg_data_i[2:0];
        CFG_DECIM:   decim_d     = cfg_data_i;
        CFG_RECLEN:  reclen_d    = cfg_data_i[12:0];
        CFG_PRETRIG: pretrig_d   = cfg_data_i[11:0];
        CFG_TRIGCTL: trigctl_d   = cfg_data_i[4:0];
        CFG_LEVEL:   level_d     = cfg_data_i;
        CFG_HYST:    hyst_d      = cfg_data_i;
        CFG_TIMEOUT: tmo_d       = cfg_data_i;
        default: ;
      endcase
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q <= 3'd1;
      decim_q     <= 16'd1;
      reclen_q    <= 13'd1;
      pretrig_q   <= '0;
      trigctl_q   <= '0;
      level_q     <= 16'h8000;
      hyst_q      <= '0;
      tmo_q       <= 16'd100;
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      fw_q        <= '0;
      wf_q        <= '0;
      start_q     <= '0;
      post_q      <= '0;
      sc_q        <= '0;
      armed_q     <= '0;
      seen_q      <= 1'b0;
      edge_q      <= 1'b0;
      wcnt_q      <= '0;
      rstat_q     <= '0;
      tout_q      <= 1'b0;
      rdok_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slots_cfg_q <= slots_cfg_d;
      decim_q     <= decim_d;
      reclen_q    <= reclen_d;
      pretrig_q   <= pretrig_d;
      trigctl_q   <= trigctl_d;
      level_q     <= level_d;
      hyst_q      <= hyst_d;
      tmo_q       <= tmo_d;
      state_q     <= state_d;
      phase_q     <= phase_d;
      fw_q        <= fw_d;
      wf_q        <= wf_d;
      start_q     <= start_d;
      post_q      <= post_d;
      sc_q        <= sc_d;
      armed_q     <= armed_d;
      seen_q      <= seen_d;
      edge_q      <= edge_d;
      wcnt_q      <= wcnt_d;
      rstat_q     <= rstat_d;
      tout_q      <= tout_d;
      rdok_q      <= rdok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> sv/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/scp_lane.sv
// One channel lane: box-car sum and bit-serial average with saturation.
`timescale 1ns / 1ps
module scp_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scp_pkg::lane_ctl_t                ctl_i,
  input  logic                              en_i,
  input  logic [scp_pkg::CODE_W-1:0]        code_i,
  input  logic [scp_pkg::DEC_W-1:0]         dec_i,
  output logic                              busy_o,
  output logic [scp_pkg::SAMPLE_W-1:0]      avg_o
);
  import scp_pkg::*;

  localparam int QW = SUM_W + 2;

  logic [SUM_W-1:0] sum_q, sum_d, sum_add;
  logic [QW-1:0]    quo_q, quo_d;
  logic [DEC_W-1:0] rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEC_W:0]   rem_sh;

  always_comb begin
    sum_add = (en_i && ctl_i.scan) ? sum_q + SUM_W'(code_i) : sum_q;
    sum_d   = sum_add;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    rem_sh  = {rem_q, quo_q[QW-1]};
    if (ctl_i.clr) begin
      sum_d = '0;
    end else if (ctl_i.fin) begin
      // sum times four, then shift it through the restoring divider
      quo_d  = {sum_add, 2'b00};
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      sum_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dec_i}) begin
        rem_d = DEC_W'(rem_sh - {1'b0, dec_i});
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEC_W-1:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(QW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign avg_o  = (|quo_q[QW-1:SAMPLE_W]) ? SAMPLE_MAX : quo_q[SAMPLE_W-1:0];

endmodule

>>> sv/scp_checker.sv
// Port-level checks on the scope capture trigger, bound to the top level.
`timescale 1ns / 1ps
module scp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [scp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import scp_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one request at a time: no accept right after an accept
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // active flag follows the reported phase
  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3] ==
      (m_axis_tdata[2:0] == PH_FILLING || m_axis_tdata[2:0] == PH_WAITING ||
       m_axis_tdata[2:0] == PH_POST)))
    else $error("active flag disagrees with phase");

  // a nonzero trigger position needs a real trigger
  a_tpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29:18] != 12'd0 |-> m_axis_tdata[4])
    else $error("trigger position without trigger");

  // failed reads return no data
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[47:46] != RD_OK |-> m_axis_tdata[45:30] == 16'd0)
    else $error("data on failed read");

endmodule

bind scope_capture_trigger scp_checker u_scp_checker (.*);
